// File: sv/btess_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier stroke tessellator package
// Shared types and constants of the tessellator: transaction payloads, the
// queued job record, the sequencer states and the multiplier schedule.
// ----------------------------------------------------------------------------
package btess_pkg;

   localparam int MAX_SEGMENTS    = 16;
   localparam int COORD_FRAC_BITS = 4;
   localparam int SCALE_SHIFT     = COORD_FRAC_BITS + 16;
   localparam int ACC_W           = 56;
   localparam int MUL_A_W         = 36;
   localparam int MUL_B_W         = 25;
   localparam int PROD_W          = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W         = 41;
   localparam int DIV_D_W         = 25;
   localparam int SQ_W            = 50;
   localparam int SQ_ROOT_W       = SQ_W / 2;
   localparam int SQ_REM_W        = SQ_ROOT_W + 3;

   typedef struct packed {
      logic signed [15:0] p0_x;
      logic signed [15:0] p0_y;
      logic signed [15:0] p1_x;
      logic signed [15:0] p1_y;
      logic signed [15:0] p2_x;
      logic signed [15:0] p2_y;
      logic signed [15:0] p3_x;
      logic signed [15:0] p3_y;
      logic [7:0]         stroke_width;
      logic [4:0]         segment_count;
   } req_type;

   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic [31:0]        vertex_color;
      logic               last_vertex;
   } rsp_type;

   typedef struct packed {
      logic [7:0][15:0] points;
      logic [6:0]       half_width;
      logic [4:0]       seg_total;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TDIV,
      ST_MUL,
      ST_ABS,
      ST_SHIFT,
      ST_SQRT,
      ST_DIVX,
      ST_DIVY,
      ST_EMIT_L,
      ST_EMIT_R
   } back_state_type;

   typedef enum logic [4:0] {
      MUL_SS, MUL_ST, MUL_TT,
      MUL_W0, MUL_W1, MUL_W2, MUL_W3,
      MUL_BX0, MUL_BX1, MUL_BX2, MUL_BX3,
      MUL_BY0, MUL_BY1, MUL_BY2, MUL_BY3,
      MUL_DX0, MUL_DX1, MUL_DX2,
      MUL_DY0, MUL_DY1, MUL_DY2,
      MUL_SQX, MUL_SQY,
      MUL_OFX, MUL_OFY
   } mul_op_type;

endpackage

// File: sv/cubic_bezier_stroke_tessellator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier stroke tessellator
// Each curve point runs a serial divider for t, the shared multiplier, the
// normalising shifts, a serial square root, two tangent divisions and two
// emit states; a zero tangent skips the divisions. A curve of n segments
// gives 4n vertices over 2n points. Reset is synchronous and clears all
// control state and the colour register; three more curves can wait.
// ----------------------------------------------------------------------------
module cubic_bezier_stroke_tessellator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  btess_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output btess_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   logic [31:0]        draw_color_ff;
   logic               f_valid, f_ready, q_valid, q_ready;
   btess_pkg::job_type f_job, q_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_color_ff <= 32'd0;
      end else if (csr_wr_en) begin
         draw_color_ff <= csr_wr_data;
      end
   end

   btess_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job_data  (f_job)
   );

   btess_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_job),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_job)
   );

   btess_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job_ready  (q_ready),
      .job_data   (q_job),
      .draw_color (draw_color_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: sv/btess_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier stroke tessellator front end
// Accepts curve transactions, clamps the segment count, halves the stroke
// width and holds the resulting job in a register for the queue.
// ----------------------------------------------------------------------------
module btess_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  btess_pkg::req_type req_data,
   output logic               job_valid,
   input  logic               job_ready,
   output btess_pkg::job_type job_data
);

   logic               valid_ff, valid_in;
   btess_pkg::job_type job_ff, job_in;
   logic               take;

   assign req_ready = !valid_ff || job_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      job_in = job_ff;
      valid_in = valid_ff;
      if (job_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in = 1'b1;
         job_in.points = {req_data.p3_y, req_data.p3_x, req_data.p2_y, req_data.p2_x,
                          req_data.p1_y, req_data.p1_x, req_data.p0_y, req_data.p0_x};
         job_in.half_width = req_data.stroke_width[7:1];
         if (req_data.segment_count == 5'd0) begin
            job_in.seg_total = 5'd1;
         end else if (req_data.segment_count > 5'(btess_pkg::MAX_SEGMENTS)) begin
            job_in.seg_total = 5'(btess_pkg::MAX_SEGMENTS);
         end else begin
            job_in.seg_total = req_data.segment_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job_data  = job_ff;

endmodule

// File: sv/btess_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier stroke tessellator job queue
// Two-entry queue that decouples the front end from the evaluation engine.
// ----------------------------------------------------------------------------
module btess_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  btess_pkg::job_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output btess_pkg::job_type out_data
);

   btess_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("Job queue count out of range.");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("Job queue count did not follow a push.");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Job queue pointers differ while empty.");

endmodule

// File: sv/btess_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier stroke tessellator evaluation engine
// Walks the curve points of one job with a shared multiplier, a serial
// square root and a serial divider, and emits the offset vertices.
// ----------------------------------------------------------------------------
module btess_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  btess_pkg::job_type job_data,
   input  logic [31:0]        draw_color,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output btess_pkg::rsp_type rsp_data
);

   localparam int AW = btess_pkg::ACC_W;

   btess_pkg::back_state_type state_ff, state_in;
   btess_pkg::mul_op_type     op_ff, op_in;
   btess_pkg::job_type        job_ff, job_in;
   logic [4:0]                seg_ff, seg_in;
   logic                      half_ff, half_in;
   logic                      wb_ff, wb_in;
   logic signed [btess_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [33:0]               s2_ff, s2_in, st_ff, st_in, t2_ff, t2_in;
   logic [3:0][33:0]          w_ff, w_in;
   logic signed [AW-1:0]      bx_ff, bx_in, by_ff, by_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [AW-1:0]      mx_ff, mx_in, my_ff, my_in;
   logic [AW-1:0]             ax_ff, ax_in, ay_ff, ay_in;
   logic [btess_pkg::SQ_W-1:0]      sq_ff, sq_in, rad_ff, rad_in;
   logic [btess_pkg::SQ_REM_W-1:0]  srem_ff, srem_in;
   logic [btess_pkg::SQ_ROOT_W-1:0] root_ff, root_in;
   logic [4:0]                scnt_ff, scnt_in;
   logic [btess_pkg::DIV_D_W-1:0]   drem_ff, drem_in, dden_ff, dden_in;
   logic [btess_pkg::DIV_N_W-1:0]   dquo_ff, dquo_in;
   logic [5:0]                dcnt_ff, dcnt_in;
   logic [16:0]               t_ff, t_in;
   logic signed [17:0]        ux_ff, ux_in, uy_ff, uy_in;
   logic                      out_valid_ff, out_valid_in;
   btess_pkg::rsp_type        out_ff, out_in;

   logic [16:0]               s_val;
   logic signed [btess_pkg::MUL_A_W-1:0] a_op;
   logic signed [btess_pkg::MUL_B_W-1:0] b_op;
   logic signed [btess_pkg::PROD_W-1:0]  prod3;
   logic signed [15:0]        pts [8];
   logic [btess_pkg::DIV_D_W:0]     dsh;
   logic                      dge;
   logic [btess_pkg::DIV_N_W-1:0]   dquo_next;
   logic [btess_pkg::DIV_D_W-1:0]   drem_next;
   logic [btess_pkg::SQ_REM_W-1:0]  ssh, strial;
   logic                      div_start;
   logic [btess_pkg::DIV_N_W-1:0]   div_dvd;
   logic [btess_pkg::DIV_D_W-1:0]   div_den;
   logic                      out_free;
   logic signed [AW-1:0]      offx, offy;
   logic [16:0]               qv;

   function automatic logic signed [15:0] to_coord(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      logic signed [AW-33:0] hi;
      r  = v + AW'(64'sd2147483648);
      hi = r[AW-1:32];
      if (hi > (AW-32)'(32767)) begin
         return 16'sd32767;
      end else if (hi < -(AW-32)'(32768)) begin
         return -16'sd32768;
      end
      return hi[15:0];
   endfunction

   function automatic logic signed [24:0] pdiff(input logic signed [15:0] hi_p,
                                                input logic signed [15:0] lo_p);
      logic signed [16:0] d;
      d = 17'(hi_p) - 17'(lo_p);
      return 25'(d);
   endfunction

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         pts[k] = job_ff.points[k];
      end
   end

   assign s_val    = 17'h10000 - t_ff;
   assign out_free = !out_valid_ff || rsp_ready;
   assign offx     = mx_ff <<< btess_pkg::SCALE_SHIFT;
   assign offy     = my_ff <<< btess_pkg::SCALE_SHIFT;
   assign prod3    = prod_ff + (prod_ff <<< 1);

   assign dsh       = {drem_ff, dquo_ff[btess_pkg::DIV_N_W-1]};
   assign dge       = dsh >= {1'b0, dden_ff};
   assign drem_next = dge ? btess_pkg::DIV_D_W'(dsh - {1'b0, dden_ff})
                          : dsh[btess_pkg::DIV_D_W-1:0];
   assign dquo_next = {dquo_ff[btess_pkg::DIV_N_W-2:0], dge};
   assign qv        = dquo_next[16:0];

   assign ssh    = {srem_ff[btess_pkg::SQ_REM_W-3:0], rad_ff[btess_pkg::SQ_W-1 -: 2]};
   assign strial = btess_pkg::SQ_REM_W'({root_ff, 2'b01});

   always_comb begin
      a_op = '0;
      b_op = '0;
      case (op_ff)
         btess_pkg::MUL_SS: begin a_op = 36'(s_val); b_op = 25'(s_val); end
         btess_pkg::MUL_ST: begin a_op = 36'(s_val); b_op = 25'(t_ff); end
         btess_pkg::MUL_TT: begin a_op = 36'(t_ff);  b_op = 25'(t_ff); end
         btess_pkg::MUL_W0: begin a_op = 36'(s2_ff); b_op = 25'(s_val); end
         btess_pkg::MUL_W1: begin a_op = 36'(s2_ff); b_op = 25'(t_ff); end
         btess_pkg::MUL_W2: begin a_op = 36'(st_ff); b_op = 25'(t_ff); end
         btess_pkg::MUL_W3: begin a_op = 36'(t2_ff); b_op = 25'(t_ff); end
         btess_pkg::MUL_BX0: begin a_op = 36'(w_ff[0]); b_op = 25'(pts[0]); end
         btess_pkg::MUL_BX1: begin a_op = 36'(w_ff[1]); b_op = 25'(pts[2]); end
         btess_pkg::MUL_BX2: begin a_op = 36'(w_ff[2]); b_op = 25'(pts[4]); end
         btess_pkg::MUL_BX3: begin a_op = 36'(w_ff[3]); b_op = 25'(pts[6]); end
         btess_pkg::MUL_BY0: begin a_op = 36'(w_ff[0]); b_op = 25'(pts[1]); end
         btess_pkg::MUL_BY1: begin a_op = 36'(w_ff[1]); b_op = 25'(pts[3]); end
         btess_pkg::MUL_BY2: begin a_op = 36'(w_ff[2]); b_op = 25'(pts[5]); end
         btess_pkg::MUL_BY3: begin a_op = 36'(w_ff[3]); b_op = 25'(pts[7]); end
         btess_pkg::MUL_DX0: begin a_op = 36'(s2_ff); b_op = pdiff(pts[2], pts[0]); end
         btess_pkg::MUL_DX1: begin a_op = 36'(st_ff); b_op = pdiff(pts[4], pts[2]); end
         btess_pkg::MUL_DX2: begin a_op = 36'(t2_ff); b_op = pdiff(pts[6], pts[4]); end
         btess_pkg::MUL_DY0: begin a_op = 36'(s2_ff); b_op = pdiff(pts[3], pts[1]); end
         btess_pkg::MUL_DY1: begin a_op = 36'(st_ff); b_op = pdiff(pts[5], pts[3]); end
         btess_pkg::MUL_DY2: begin a_op = 36'(t2_ff); b_op = pdiff(pts[7], pts[5]); end
         btess_pkg::MUL_SQX: begin a_op = 36'(ax_ff[23:0]); b_op = 25'(ax_ff[23:0]); end
         btess_pkg::MUL_SQY: begin a_op = 36'(ay_ff[23:0]); b_op = 25'(ay_ff[23:0]); end
         btess_pkg::MUL_OFX: begin a_op = 36'(uy_ff); b_op = 25'(job_ff.half_width); end
         btess_pkg::MUL_OFY: begin a_op = 36'(ux_ff); b_op = 25'(job_ff.half_width); end
         default: begin a_op = '0; b_op = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;   op_in = op_ff;       job_in = job_ff;
      seg_in = seg_ff;       half_in = half_ff;   wb_in = wb_ff;
      prod_in = prod_ff;     s2_in = s2_ff;       st_in = st_ff;
      t2_in = t2_ff;         w_in = w_ff;         bx_in = bx_ff;
      by_in = by_ff;         dx_in = dx_ff;       dy_in = dy_ff;
      mx_in = mx_ff;         my_in = my_ff;       ax_in = ax_ff;
      ay_in = ay_ff;         sq_in = sq_ff;       rad_in = rad_ff;
      srem_in = srem_ff;     root_in = root_ff;   scnt_in = scnt_ff;
      t_in = t_ff;           ux_in = ux_ff;       uy_in = uy_ff;
      out_in = out_ff;       job_ready = 1'b0;
      out_valid_in = rsp_ready ? 1'b0 : out_valid_ff;
      div_start = 1'b0;
      div_dvd = '0;
      div_den = '0;

      case (state_ff)
         btess_pkg::ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in = job_data;
               seg_in = 5'd0;
               half_in = 1'b0;
               div_start = 1'b1;
               div_dvd = '0;
               div_den = btess_pkg::DIV_D_W'(job_data.seg_total);
               state_in = btess_pkg::ST_TDIV;
            end
         end
         btess_pkg::ST_TDIV: begin
            if (dcnt_ff == 6'(btess_pkg::DIV_N_W - 1)) begin
               t_in = qv;
               op_in = btess_pkg::MUL_SS;
               wb_in = 1'b0;
               state_in = btess_pkg::ST_MUL;
            end
         end
         btess_pkg::ST_MUL: begin
            if (!wb_ff) begin
               prod_in = btess_pkg::PROD_W'(a_op) * btess_pkg::PROD_W'(b_op);
               wb_in = 1'b1;
            end else begin
               wb_in = 1'b0;
               op_in = btess_pkg::mul_op_type'(5'(op_ff) + 5'd1);
               case (op_ff)
                  btess_pkg::MUL_SS: s2_in = prod_ff[33:0];
                  btess_pkg::MUL_ST: st_in = prod_ff[33:0];
                  btess_pkg::MUL_TT: t2_in = prod_ff[33:0];
                  btess_pkg::MUL_W0: w_in[0] = prod_ff[49:16];
                  btess_pkg::MUL_W1: w_in[1] = prod3[49:16];
                  btess_pkg::MUL_W2: w_in[2] = prod3[49:16];
                  btess_pkg::MUL_W3: w_in[3] = prod_ff[49:16];
                  btess_pkg::MUL_BX0: bx_in = prod_ff[AW-1:0];
                  btess_pkg::MUL_BX1, btess_pkg::MUL_BX2, btess_pkg::MUL_BX3:
                     bx_in = bx_ff + prod_ff[AW-1:0];
                  btess_pkg::MUL_BY0: by_in = prod_ff[AW-1:0];
                  btess_pkg::MUL_BY1, btess_pkg::MUL_BY2, btess_pkg::MUL_BY3:
                     by_in = by_ff + prod_ff[AW-1:0];
                  btess_pkg::MUL_DX0: dx_in = prod_ff[AW-1:0];
                  btess_pkg::MUL_DX1: dx_in = dx_ff + (prod_ff[AW-1:0] <<< 1);
                  btess_pkg::MUL_DX2: dx_in = dx_ff + prod_ff[AW-1:0];
                  btess_pkg::MUL_DY0: dy_in = prod_ff[AW-1:0];
                  btess_pkg::MUL_DY1: dy_in = dy_ff + (prod_ff[AW-1:0] <<< 1);
                  btess_pkg::MUL_DY2: begin
                     dy_in = dy_ff + prod_ff[AW-1:0];
                     state_in = btess_pkg::ST_ABS;
                  end
                  btess_pkg::MUL_SQX: sq_in = prod_ff[btess_pkg::SQ_W-1:0];
                  btess_pkg::MUL_SQY: begin
                     rad_in = sq_ff + prod_ff[btess_pkg::SQ_W-1:0];
                     srem_in = '0;
                     root_in = '0;
                     scnt_in = 5'd0;
                     state_in = btess_pkg::ST_SQRT;
                  end
                  btess_pkg::MUL_OFX: mx_in = prod_ff[AW-1:0];
                  btess_pkg::MUL_OFY: begin
                     my_in = prod_ff[AW-1:0];
                     state_in = btess_pkg::ST_EMIT_L;
                  end
                  default: state_in = btess_pkg::ST_IDLE;
               endcase
            end
         end
         btess_pkg::ST_ABS: begin
            ax_in = dx_ff[AW-1] ? AW'(-dx_ff) : AW'(dx_ff);
            ay_in = dy_ff[AW-1] ? AW'(-dy_ff) : AW'(dy_ff);
            state_in = btess_pkg::ST_SHIFT;
         end
         btess_pkg::ST_SHIFT: begin
            if ((|ax_ff[AW-1:24]) || (|ay_ff[AW-1:24])) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end else begin
               op_in = btess_pkg::MUL_SQX;
               wb_in = 1'b0;
               state_in = btess_pkg::ST_MUL;
            end
         end
         btess_pkg::ST_SQRT: begin
            rad_in = rad_ff << 2;
            scnt_in = scnt_ff + 5'd1;
            if (ssh >= strial) begin
               srem_in = ssh - strial;
               root_in = {root_ff[btess_pkg::SQ_ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = ssh;
               root_in = {root_ff[btess_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
            if (scnt_ff == 5'(btess_pkg::SQ_ROOT_W - 1)) begin
               if (root_in == '0) begin
                  ux_in = '0;
                  uy_in = '0;
                  op_in = btess_pkg::MUL_OFX;
                  wb_in = 1'b0;
                  state_in = btess_pkg::ST_MUL;
               end else begin
                  div_start = 1'b1;
                  div_dvd = btess_pkg::DIV_N_W'({ax_ff[23:0], 16'h0000});
                  div_den = root_in;
                  state_in = btess_pkg::ST_DIVX;
               end
            end
         end
         btess_pkg::ST_DIVX: begin
            if (dcnt_ff == 6'(btess_pkg::DIV_N_W - 1)) begin
               ux_in = dx_ff[AW-1] ? -18'(qv) : 18'(qv);
               div_start = 1'b1;
               div_dvd = btess_pkg::DIV_N_W'({ay_ff[23:0], 16'h0000});
               div_den = root_ff;
               state_in = btess_pkg::ST_DIVY;
            end
         end
         btess_pkg::ST_DIVY: begin
            if (dcnt_ff == 6'(btess_pkg::DIV_N_W - 1)) begin
               uy_in = dy_ff[AW-1] ? -18'(qv) : 18'(qv);
               op_in = btess_pkg::MUL_OFX;
               wb_in = 1'b0;
               state_in = btess_pkg::ST_MUL;
            end
         end
         btess_pkg::ST_EMIT_L: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.vertex_x = to_coord(bx_ff - offx);
               out_in.vertex_y = to_coord(by_ff + offy);
               out_in.vertex_color = draw_color;
               out_in.last_vertex = 1'b0;
               state_in = btess_pkg::ST_EMIT_R;
            end
         end
         btess_pkg::ST_EMIT_R: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.vertex_x = to_coord(bx_ff + offx);
               out_in.vertex_y = to_coord(by_ff - offy);
               out_in.vertex_color = draw_color;
               out_in.last_vertex = half_ff && (seg_ff == job_ff.seg_total - 5'd1);
               if (half_ff && (seg_ff == job_ff.seg_total - 5'd1)) begin
                  seg_in = 5'd0;
                  half_in = 1'b0;
                  state_in = btess_pkg::ST_IDLE;
               end else begin
                  if (half_ff) begin
                     seg_in = seg_ff + 5'd1;
                     half_in = 1'b0;
                  end else begin
                     half_in = 1'b1;
                  end
                  div_start = 1'b1;
                  div_dvd = btess_pkg::DIV_N_W'({seg_ff + 5'd1, 16'h0000});
                  div_den = btess_pkg::DIV_D_W'(job_ff.seg_total);
                  state_in = btess_pkg::ST_TDIV;
               end
            end
         end
         default: state_in = btess_pkg::ST_IDLE;
      endcase

      drem_in = drem_next;
      dquo_in = dquo_next;
      dden_in = dden_ff;
      dcnt_in = dcnt_ff + 6'd1;
      if (div_start) begin
         drem_in = '0;
         dquo_in = div_dvd;
         dden_in = div_den;
         dcnt_in = 6'd0;
      end else if (!(state_ff == btess_pkg::ST_TDIV || state_ff == btess_pkg::ST_DIVX ||
                     state_ff == btess_pkg::ST_DIVY)) begin
         drem_in = drem_ff;
         dquo_in = dquo_ff;
         dcnt_in = dcnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btess_pkg::ST_IDLE;
         op_ff        <= btess_pkg::MUL_SS;
         wb_ff        <= 1'b0;
         seg_ff       <= 5'd0;
         half_ff      <= 1'b0;
         scnt_ff      <= 5'd0;
         dcnt_ff      <= 6'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         wb_ff        <= wb_in;
         seg_ff       <= seg_in;
         half_ff      <= half_in;
         scnt_ff      <= scnt_in;
         dcnt_ff      <= dcnt_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff  <= job_in;   prod_ff <= prod_in;  s2_ff <= s2_in;
      st_ff   <= st_in;    t2_ff   <= t2_in;    w_ff  <= w_in;
      bx_ff   <= bx_in;    by_ff   <= by_in;    dx_ff <= dx_in;
      dy_ff   <= dy_in;    mx_ff   <= mx_in;    my_ff <= my_in;
      ax_ff   <= ax_in;    ay_ff   <= ay_in;    sq_ff <= sq_in;
      rad_ff  <= rad_in;   srem_ff <= srem_in;  root_ff <= root_in;
      drem_ff <= drem_in;  dquo_ff <= dquo_in;  dden_ff <= dden_in;
      t_ff    <= t_in;     ux_ff   <= ux_in;    uy_ff <= uy_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != btess_pkg::ST_IDLE) |->
         (job_ff.seg_total != 5'd0 && job_ff.seg_total <= 5'(btess_pkg::MAX_SEGMENTS)))
      else $error("Active job has an unclamped segment count.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != btess_pkg::ST_IDLE) |-> (seg_ff < job_ff.seg_total))
      else $error("Segment walk ran past the segment count.");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == btess_pkg::ST_DIVX || state_ff == btess_pkg::ST_DIVY) |->
         (root_ff != '0))
      else $error("Tangent division started with a zero length.");

endmodule
